>>> hdl/tile_column_blitter_assert.svh
// Assertion macros for the tile column blitter.
// Each use names the check, the antecedent and the consequent.
`ifndef TILE_COLUMN_BLITTER_ASSERT_SVH
`define TILE_COLUMN_BLITTER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define TCB_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("tile_column_blitter: check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define TCB_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("tile_column_blitter: check failed");

`endif

>>> hdl/tcb_pkg.sv
package tcb_pkg;

    // Operation codes carried in tuser
    typedef enum logic [1:0] {
        OP_DRAW = 2'd0,
        OP_FILL = 2'd1,
        OP_READ = 2'd2
    } t_op;

    // Configuration register indexes
    localparam logic [2:0] CFG_TILE_FORMAT  = 3'd0;
    localparam logic [2:0] CFG_TILE_WIDTH   = 3'd1;
    localparam logic [2:0] CFG_ODD_FRAME    = 3'd2;
    localparam logic [2:0] CFG_SCROLL_X     = 3'd3;
    localparam logic [2:0] CFG_SCROLL_Y     = 3'd4;
    localparam logic [2:0] CFG_FIRST_COLUMN = 3'd5;
    localparam logic [2:0] CFG_BUFFER_WIDTH = 3'd6;
    localparam logic [2:0] CFG_CURRENT_PAGE = 3'd7;

    // Tile formats
    localparam logic [1:0] FMT_PLAIN       = 2'd0;
    localparam logic [1:0] FMT_MASKED      = 2'd1;
    localparam logic [1:0] FMT_FRAMES      = 2'd2;
    localparam logic [1:0] FMT_MASK_FRAMES = 2'd3;

    localparam logic [7:0] BYTE_ONES  = 8'hFF;
    localparam logic [2:0] PAGE_BITS  = 3'h7;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 16;

    typedef struct packed {
        logic capture;   // latch the accepted transaction
        logic lookup;    // address decode and buffer read
        logic commit;    // merge, write back, load output register
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;  // output register empty or being drained
    } t_dp_sts;

    function automatic logic [7:0] bit_reverse(input logic [7:0] b);
        logic [7:0] v;
        v = ((b & 8'hAA) >> 1) | ((b & 8'h55) << 1);
        v = ((v & 8'hCC) >> 2) | ((v & 8'h33) << 2);
        v = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
        return v;
    endfunction

endpackage

>>> hdl/tcb_ctrl.sv
module tcb_ctrl
    import tcb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_MERGE
    } t_state;

    t_state r_state;
    logic   r_in_ready;

    assign o_in_ready    = r_in_ready;
    assign o_cmd.capture = i_in_valid && r_in_ready;
    assign o_cmd.lookup  = (r_state == ST_LOOKUP);
    assign o_cmd.commit  = (r_state == ST_MERGE) && i_sts.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid && r_in_ready) begin
                        r_state    <= ST_LOOKUP;
                        r_in_ready <= 1'b0;
                    end else begin
                        r_in_ready <= 1'b1;
                    end
                end
                ST_LOOKUP: begin
                    r_state <= ST_MERGE;
                end
                ST_MERGE: begin
                    // hold until the output register can take the result
                    if (i_sts.out_free) begin
                        r_state    <= ST_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= ST_IDLE;
                    r_in_ready <= 1'b0;
                end
            endcase
        end
    end

endmodule

>>> hdl/tcb_datapath.sv
module tcb_datapath
    import tcb_pkg::*;
#(
    parameter int BUFFER_COLUMNS = 128
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [7:0]            i_cfg_wdata,
    input  logic [1:0]            i_in_user,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    localparam int         AW    = (BUFFER_COLUMNS > 1) ? $clog2(BUFFER_COLUMNS) : 1;
    localparam logic [7:0] COLS8 = 8'(BUFFER_COLUMNS);

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_FILL,
        ACT_READ,
        ACT_TOP,
        ACT_BOT,
        ACT_KEEP
    } t_act;

    // configuration
    logic [1:0] r_tile_format;
    logic [6:0] r_tile_width;
    logic       r_odd_frame;
    logic [7:0] r_scroll_x;
    logic [7:0] r_scroll_y;
    logic [6:0] r_first_column;
    logic [7:0] r_buffer_width;
    logic [2:0] r_current_page;

    // captured transaction
    t_op        r_op;
    logic [7:0] r_tx;
    logic [7:0] r_ty;
    logic [6:0] r_col;
    logic       r_transp;
    logic       r_flip_x;
    logic       r_flip_y;
    logic       r_inverse;
    logic [7:0] r_byte_a;
    logic [7:0] r_byte_b;
    logic [7:0] r_byte_c;

    // lookup results
    t_act       r_act;
    logic [AW-1:0] r_addr;
    logic [7:0] r_bm;
    logic [7:0] r_mk;
    logic [2:0] r_shift;
    logic [7:0] r_rd;
    logic       r_rd_ok;

    // buffer
    logic [7:0]                r_mem [BUFFER_COLUMNS];
    logic [BUFFER_COLUMNS-1:0] r_valid;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_written;

    // lookup stage logic
    logic [7:0]        w_sx, w_sy, w_bx, w_width;
    logic [6:0]        w_off;
    logic signed [8:0] w_d;
    logic              w_in_tile, w_bx_in, w_col_in, w_top, w_bot;
    logic [7:0]        w_bm_sel, w_mk_sel, w_bm_fy, w_mk_fy, w_bm;
    t_act              w_act;
    logic [AW-1:0]     w_addr;

    always_comb begin
        w_sx      = r_tx - r_scroll_x;
        w_sy      = r_ty - r_scroll_y;
        w_off     = r_flip_x ? (r_tile_width - 7'd1 - r_col) : r_col;
        w_bx      = w_sx + {1'b0, w_off} - {1'b0, r_first_column};
        w_width   = (r_buffer_width < COLS8) ? r_buffer_width : COLS8;
        w_in_tile = r_col < r_tile_width;
        w_bx_in   = !w_bx[7] && (w_bx < w_width);
        w_col_in  = {1'b0, r_col} < w_width;

        case (r_tile_format)
            FMT_MASKED: begin
                w_bm_sel = r_byte_a;
                w_mk_sel = r_transp ? r_byte_b : BYTE_ONES;
            end
            FMT_FRAMES: begin
                w_bm_sel = r_odd_frame ? r_byte_b : r_byte_a;
                w_mk_sel = r_transp ? w_bm_sel : BYTE_ONES;
            end
            FMT_MASK_FRAMES: begin
                w_bm_sel = r_odd_frame ? r_byte_c : r_byte_a;
                w_mk_sel = r_transp ? r_byte_b : BYTE_ONES;
            end
            default: begin
                w_bm_sel = r_byte_a;
                w_mk_sel = r_transp ? w_bm_sel : BYTE_ONES;
            end
        endcase
        w_bm_fy = r_flip_y ? bit_reverse(w_bm_sel) : w_bm_sel;
        w_mk_fy = r_flip_y ? bit_reverse(w_mk_sel) : w_mk_sel;
        w_bm    = r_inverse ? (~w_bm_fy & w_mk_fy) : w_bm_fy;

        // top half: tile row band starts on this page
        w_top = !w_sy[7] && (w_sy[6:3] == {1'b0, r_current_page});
        // bottom half: tile starts up to seven rows above this page
        w_d   = $signed({3'b000, r_current_page, 3'b000}) - $signed({w_sy[7], w_sy});
        w_bot = !w_top && !w_d[8] && (w_d[7:3] == 5'd0);

        w_act  = ACT_NONE;
        w_addr = r_col[AW-1:0];
        case (r_op)
            OP_DRAW: begin
                w_addr = w_bx[AW-1:0];
                if (w_in_tile && w_bx_in) begin
                    if (w_top) begin
                        w_act = ACT_TOP;
                    end else if (w_bot) begin
                        w_act = ACT_BOT;
                    end else begin
                        w_act = ACT_KEEP;
                    end
                end
            end
            OP_FILL: begin
                if (w_col_in) begin
                    w_act = ACT_FILL;
                end
            end
            OP_READ: begin
                if (w_col_in) begin
                    w_act = ACT_READ;
                end
            end
            default: begin
                w_act = ACT_NONE;
            end
        endcase
    end

    // merge stage logic
    logic [7:0] w_cur, w_mk_sh, w_bm_sh, w_new, w_out_byte;
    logic       w_we, w_written;

    always_comb begin
        w_cur   = r_rd_ok ? r_rd : 8'h00;
        w_mk_sh = (r_act == ACT_TOP) ? (r_mk << r_shift) : (r_mk >> r_shift);
        w_bm_sh = (r_act == ACT_TOP) ? (r_bm << r_shift) : (r_bm >> r_shift);
        w_new      = (w_cur & ~w_mk_sh) | w_bm_sh;
        w_we       = 1'b0;
        w_written  = 1'b0;
        w_out_byte = 8'h00;
        case (r_act)
            ACT_FILL: begin
                w_new      = r_byte_a;
                w_we       = 1'b1;
                w_written  = 1'b1;
                w_out_byte = r_byte_a;
            end
            ACT_READ: begin
                w_out_byte = w_cur;
            end
            ACT_TOP, ACT_BOT: begin
                w_we       = 1'b1;
                w_written  = 1'b1;
                w_out_byte = w_new;
            end
            ACT_KEEP: begin
                w_out_byte = w_cur;
            end
            default: begin
                w_out_byte = 8'h00;
            end
        endcase
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_format  <= FMT_PLAIN;
            r_tile_width   <= 7'd8;
            r_odd_frame    <= 1'b0;
            r_scroll_x     <= 8'h00;
            r_scroll_y     <= 8'h00;
            r_first_column <= 7'd0;
            r_buffer_width <= 8'd128;
            r_current_page <= 3'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TILE_FORMAT:  r_tile_format  <= i_cfg_wdata[1:0];
                CFG_TILE_WIDTH:   r_tile_width   <= i_cfg_wdata[6:0];
                CFG_ODD_FRAME:    r_odd_frame    <= i_cfg_wdata[0];
                CFG_SCROLL_X:     r_scroll_x     <= i_cfg_wdata;
                CFG_SCROLL_Y:     r_scroll_y     <= i_cfg_wdata;
                CFG_FIRST_COLUMN: r_first_column <= i_cfg_wdata[6:0];
                CFG_BUFFER_WIDTH: r_buffer_width <= i_cfg_wdata;
                CFG_CURRENT_PAGE: r_current_page <= i_cfg_wdata[2:0] & PAGE_BITS;
                default:          r_tile_format  <= r_tile_format;
            endcase
        end
    end

    // payload capture and lookup registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= t_op'(i_in_user);
            r_tx      <= i_in_data[7:0];
            r_ty      <= i_in_data[15:8];
            r_col     <= i_in_data[22:16];
            r_transp  <= i_in_data[23];
            r_flip_x  <= i_in_data[24];
            r_flip_y  <= i_in_data[25];
            r_inverse <= i_in_data[26];
            r_byte_a  <= i_in_data[34:27];
            r_byte_b  <= i_in_data[42:35];
            r_byte_c  <= i_in_data[50:43];
        end
        if (i_cmd.lookup) begin
            r_addr  <= w_addr;
            r_bm    <= w_bm;
            r_mk    <= w_mk_fy;
            r_shift <= w_top ? w_sy[2:0] : w_d[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= ACT_NONE;
        end else if (i_cmd.lookup) begin
            r_act <= w_act;
        end
    end

    // buffer memory: read in lookup, write in merge
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_rd <= r_mem[w_addr];
        end
        if (i_cmd.commit && w_we) begin
            r_mem[r_addr] <= w_new;
        end
    end

    // per-column valid bits stand in for the cleared buffer after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_cmd.lookup) begin
                r_rd_ok <= r_valid[w_addr];
            end
            if (i_cmd.commit && w_we) begin
                r_valid[r_addr] <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_byte    <= w_out_byte;
            r_out_written <= w_written;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = {7'd0, r_out_written, r_out_byte};

endmodule

>>> hdl/tile_column_blitter.sv
// Tile column blitter: merges tile columns into a one-page line buffer of a
// page-organized monochrome display (one byte per column, bit 0 on top).
// Channels:
//   s_axis  one transaction per item; tuser is the operation (draw, fill,
//           read), tdata the tile position, column, render flags and bytes.
//   m_axis  exactly one result transaction per item: the buffer byte at the
//           addressed column (zero if out of range) and a flag telling if it was written.
//   i_cfg_* register writes; the user must make them only while no item is
//           in flight, and the block itself does not enforce it.
// Each item passes capture, buffer read and address decode, then merge and
// write back; the block takes no new item until the last one has been
// written back and its result loaded into the output register.
// Reset clears the control and configuration registers to their defaults and
// marks every buffer column as zero through per-column valid bits, so no clearing pass is needed;
// s_axis_tready rises in the cycle after reset is released.
// Receiver stall: the result sits in the output register; a finished item
// waits in its merge step until that register is drained, and s_axis_tready
// stays low until then.
`include "tile_column_blitter_assert.svh"

module tile_column_blitter
    import tcb_pkg::*;
#(
    parameter int BUFFER_COLUMNS = 128
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [7:0]            i_cfg_wdata,
    // input item stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tuser: operation[1:0]
    input  logic [1:0]            s_axis_tuser,
    // tdata: tile_x[7:0], tile_y[15:8], column_index[22:16], transparent[23],
    //        flip_x[24], flip_y[25], inverse[26], byte_a[34:27],
    //        byte_b[42:35], byte_c[50:43], zero pad[55:51]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: column_byte[7:0], written[8], zero pad[15:9]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencing of capture, lookup and commit
    tcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // config registers, address math, line buffer, merge, output register
    tcb_datapath #(
        .BUFFER_COLUMNS (BUFFER_COLUMNS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_user   (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

    // one item in flight: an accepted transaction drops ready and starts lookup
    `TCB_ASSERT_NEXT(a_accept_blocks, s_axis_tvalid && s_axis_tready, !s_axis_tready && w_cmd.lookup)
    // a commit never overwrites a result that is still waiting
    `TCB_ASSERT_SAME(a_commit_free, w_cmd.commit, !m_axis_tvalid || m_axis_tready)
    // every commit presents a result in the next cycle
    `TCB_ASSERT_NEXT(a_commit_shows, w_cmd.commit, m_axis_tvalid)

endmodule
